// ===== design/life_automaton_row_step_assert.svh =====
// Assertion macros of the row stepper, included by lars_queue.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef LIFE_AUTOMATON_ROW_STEP_ASSERT_SVH
`define LIFE_AUTOMATON_ROW_STEP_ASSERT_SVH

`define LARS_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define LARS_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`define LARS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lars_pkg.sv =====
// Types and constants of the Life row stepper.
// No dependencies; imported by every module of the block.
package lars_pkg;

   localparam int unsigned ROW_BITS     = 64;
   localparam int unsigned ROW_NUM_BITS = 12;
   localparam int unsigned WIDTH_BITS   = 7;
   localparam int unsigned HEIGHT_BITS  = 13;
   localparam int unsigned MAX_ROWS     = 4096;
   localparam int unsigned ROW_LIMIT    = 4096;
   localparam int unsigned HEIGHT_CAP   = (MAX_ROWS > ROW_LIMIT) ? ROW_LIMIT : MAX_ROWS;
   localparam int unsigned GRID_MIN     = 3;
   localparam int unsigned QUEUE_DEPTH  = 4;

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   typedef struct packed {
      logic [ROW_BITS-1:0]     next_cells;
      logic [ROW_NUM_BITS-1:0] row_number;
      logic                    frame_last;
   } rsp_entry_type;

   typedef struct packed {
      logic          first_valid;
      logic          second_valid;
      rsp_entry_type first;
      rsp_entry_type second;
   } queue_push_type;

endpackage

// ===== design/lars_cell.sv =====
// One column cell: holds the column's bits of the two previous rows.
// Uses lars_pkg for the B3/S23 counts; neighbours come from adjacent cells.
module lars_cell import lars_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic clear,
   input  logic row_bit,
   input  logic is_inner,
   input  logic is_edge,
   input  logic left_upper,
   input  logic left_mid,
   input  logic left_row,
   input  logic right_upper,
   input  logic right_mid,
   input  logic right_row,
   output logic upper_bit,
   output logic mid_bit,
   output logic next_bit
);

   logic       upper_ff, upper_in;
   logic       mid_ff, mid_in;
   logic [3:0] count;

   always_comb begin
      upper_in = mid_ff;
      mid_in   = row_bit;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         upper_ff <= 1'b0;
         mid_ff   <= 1'b0;
      end else if (advance) begin
         upper_ff <= upper_in;
         mid_ff   <= mid_in;
      end
   end

   always_comb begin
      count = 4'(left_upper) + 4'(upper_ff) + 4'(right_upper)
            + 4'(left_mid) + 4'(right_mid)
            + 4'(left_row) + 4'(row_bit) + 4'(right_row);
      if (is_edge) begin
         next_bit = mid_ff;
      end else begin
         next_bit = is_inner &&
                    ((count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && mid_ff));
      end
   end

   assign upper_bit = upper_ff;
   assign mid_bit   = mid_ff;

endmodule

// ===== design/lars_queue.sv =====
// Result queue: takes up to two items a cycle, hands out one while rsp_ready is high.
// Uses lars_pkg for the entry and push types, and the assertion macro header.
`include "life_automaton_row_step_assert.svh"

module lars_queue import lars_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_push_type push,
   output logic           room,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_entry_type  head
);

   localparam int unsigned PtrBits   = $clog2(QUEUE_DEPTH);
   localparam int unsigned CountBits = $clog2(QUEUE_DEPTH + 1);

   rsp_entry_type        entries_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [1:0]           push_n;
   logic                 pop;
   rsp_entry_type        lead;

   always_comb begin
      push_n    = 2'(push.first_valid) + 2'(push.second_valid);
      lead      = push.first_valid ? push.first : push.second;
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = wr_ptr_ff + PtrBits'(push_n);
      rd_ptr_in = rd_ptr_ff + PtrBits'(pop);
      count_in  = count_ff + CountBits'(push_n) - CountBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries_ff[wr_ptr_ff] <= lead;
      end
      if (push_n == 2'd2) begin
         entries_ff[wr_ptr_ff + PtrBits'(1)] <= push.second;
      end
   end

   assign room      = count_ff <= CountBits'(QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign head      = entries_ff[rd_ptr_ff];

   `LARS_ASSERT_HOLDS(a_count_bound, count_ff <= CountBits'(QUEUE_DEPTH), "queue count overrun")
   `LARS_ASSERT_IMPLIES(a_no_overflow, push_n != 2'd0, (4'(count_ff) + 4'(push_n)) <= 4'(QUEUE_DEPTH), "item pushed into full queue")
   `LARS_ASSERT_NEXT(a_pop_drains, pop && (push_n == 2'd0), count_ff == CountBits'($past(count_ff) - 1'b1), "pop did not drain queue")

endmodule

// ===== design/life_automaton_row_step.sv =====
// Life row stepper top level: configuration registers, cell chain and result queue.
// Depends on lars_pkg, lars_cell and lars_queue.
//
// Usage: rows of a frame enter on req_ (one 64-bit row per item, top row first,
// bit x is cell x). Results leave on rsp_: the next-generation row with its
// row number, and frame_last on the final item of each frame. Row 0 yields its
// own row at once, row 1 yields nothing, row r >= 2 yields computed row r-1,
// and the final row yields a second item carrying itself with frame_last set.
// A result is registered into the result queue when its row is accepted and is offered after any earlier items.
// Throughput: one row per cycle while req_ready is high. The final row of a
// frame puts two items into a four-entry result queue, and req_ready is low
// while that queue holds three or more items.
// A stalled receiver fills the queue and then holds off new rows; nothing is lost.
// Reset (synchronous) empties the queue, clears stored rows and row count, and
// sets grid_width and grid_height to 64. A write to either CSR (0x0 width,
// 0x4 height) restarts the frame; write only while the block is idle.
module life_automaton_row_step import lars_pkg::*; #(
   parameter int unsigned ROW_CELLS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ROW_BITS-1:0]     req_row_cells,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [ROW_BITS-1:0]     rsp_next_cells,
   output logic [ROW_NUM_BITS-1:0] rsp_row_number,
   output logic                    rsp_frame_last,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam logic [WIDTH_BITS-1:0]  WidthCap  = WIDTH_BITS'(ROW_CELLS);
   localparam logic [HEIGHT_BITS-1:0] HeightCap = HEIGHT_BITS'(HEIGHT_CAP);

   logic [WIDTH_BITS-1:0]   grid_width_ff, grid_width_in;
   logic [HEIGHT_BITS-1:0]  grid_height_ff, grid_height_in;
   logic [ROW_NUM_BITS-1:0] rows_seen_ff, rows_seen_in;
   logic [WIDTH_BITS-1:0]   width_act;
   logic [HEIGHT_BITS-1:0]  height_act;
   logic                    csr_write;
   logic                    accept;
   logic                    is_final;
   logic                    advance;
   logic                    clear;
   logic [ROW_CELLS-1:0]    row_bits;
   logic [ROW_CELLS-1:0]    upper_bits;
   logic [ROW_CELLS-1:0]    mid_bits;
   logic [ROW_CELLS-1:0]    next_bits;
   logic [ROW_CELLS+1:0]    row_ext;
   logic [ROW_CELLS+1:0]    upper_ext;
   logic [ROW_CELLS+1:0]    mid_ext;
   logic [ROW_BITS-1:0]     masked_row;
   logic [ROW_BITS-1:0]     gen_row;
   queue_push_type          push;
   logic                    queue_room;
   rsp_entry_type           head;

   // configuration port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_GRID_WIDTH:  grid_width_in  = csr_pwdata[WIDTH_BITS-1:0];
            REG_GRID_HEIGHT: grid_height_in = csr_pwdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
      case (csr_paddr[2])
         REG_GRID_WIDTH:  csr_prdata = 32'(grid_width_ff);
         REG_GRID_HEIGHT: csr_prdata = 32'(grid_height_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= WIDTH_BITS'(64);
         grid_height_ff <= HEIGHT_BITS'(64);
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   // clamp to the active grid size
   always_comb begin
      if (grid_width_ff < WIDTH_BITS'(GRID_MIN)) begin
         width_act = WIDTH_BITS'(GRID_MIN);
      end else if (grid_width_ff > WidthCap) begin
         width_act = WidthCap;
      end else begin
         width_act = grid_width_ff;
      end
      if (grid_height_ff < HEIGHT_BITS'(GRID_MIN)) begin
         height_act = HEIGHT_BITS'(GRID_MIN);
      end else if (grid_height_ff > HeightCap) begin
         height_act = HeightCap;
      end else begin
         height_act = grid_height_ff;
      end
   end

   // row sequencing
   assign req_ready = queue_room;
   assign accept    = req_valid && req_ready;
   assign is_final  = {1'b0, rows_seen_ff} >= (height_act - HEIGHT_BITS'(1));
   assign advance   = accept && !is_final;
   assign clear     = csr_write || (accept && is_final);

   always_comb begin
      rows_seen_in = rows_seen_ff;
      if (csr_write || (accept && is_final)) begin
         rows_seen_in = '0;
      end else if (accept) begin
         rows_seen_in = rows_seen_ff + ROW_NUM_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_seen_ff <= '0;
      end else begin
         rows_seen_ff <= rows_seen_in;
      end
   end

   // cell chain
   assign row_ext   = {1'b0, row_bits, 1'b0};
   assign upper_ext = {1'b0, upper_bits, 1'b0};
   assign mid_ext   = {1'b0, mid_bits, 1'b0};

   for (genvar x = 0; x < ROW_CELLS; x++) begin : g_col
      logic col_in, col_edge, col_inner;

      assign col_in    = width_act > WIDTH_BITS'(x);
      assign col_edge  = (x == 0) || (WIDTH_BITS'(x) == width_act - WIDTH_BITS'(1));
      assign col_inner = (x >= 1) && (WIDTH_BITS'(x + 1) < width_act);
      assign row_bits[x] = req_row_cells[x] && col_in;

      lars_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .clear       (clear),
         .row_bit     (row_bits[x]),
         .is_inner    (col_inner),
         .is_edge     (col_edge),
         .left_upper  (upper_ext[x]),
         .left_mid    (mid_ext[x]),
         .left_row    (row_ext[x]),
         .right_upper (upper_ext[x+2]),
         .right_mid   (mid_ext[x+2]),
         .right_row   (row_ext[x+2]),
         .upper_bit   (upper_bits[x]),
         .mid_bit     (mid_bits[x]),
         .next_bit    (next_bits[x])
      );
   end

   assign masked_row = ROW_BITS'(row_bits);
   assign gen_row    = ROW_BITS'(next_bits);

   // results of the accepted item
   always_comb begin
      push.first_valid        = accept && (rows_seen_ff != ROW_NUM_BITS'(1));
      push.first.next_cells   = (rows_seen_ff == '0) ? masked_row : gen_row;
      push.first.row_number   = (rows_seen_ff == '0) ? '0
                                                     : rows_seen_ff - ROW_NUM_BITS'(1);
      push.first.frame_last   = 1'b0;
      push.second_valid       = accept && is_final;
      push.second.next_cells  = masked_row;
      push.second.row_number  = rows_seen_ff;
      push.second.frame_last  = 1'b1;
   end

   lars_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (queue_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_next_cells = head.next_cells;
   assign rsp_row_number = head.row_number;
   assign rsp_frame_last = head.frame_last;

endmodule

// ===== tb/life_row_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the Life row stepper: predicts next-generation rows and checks results.
// Depends on lars_pkg for widths, limits, register indexes and the result entry type.
package life_row_scoreboard_pkg;
   import lars_pkg::*;

   class life_row_scoreboard;
      rsp_entry_type           expected_rows[$];
      bit [WIDTH_BITS-1:0]     width_reg;
      bit [HEIGHT_BITS-1:0]    height_reg;
      bit [ROW_BITS-1:0]       upper_row;
      bit [ROW_BITS-1:0]       middle_row;
      bit [ROW_NUM_BITS-1:0]   next_row;
      int                      errors;
      int                      rows_fed;
      int                      results_seen;
      int                      frames_done;

      function new();
         width_reg    = 7'd64;
         height_reg   = 13'd64;
         errors       = 0;
         rows_fed     = 0;
         results_seen = 0;
         frames_done  = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         upper_row  = '0;
         middle_row = '0;
         next_row   = '0;
      endfunction

      function void set_register(logic index, logic [31:0] value);
         if (index == REG_GRID_WIDTH) begin
            width_reg = value[WIDTH_BITS-1:0];
         end else begin
            height_reg = value[HEIGHT_BITS-1:0];
         end
         restart_frame();
      endfunction

      function int active_width();
         int w;
         w = width_reg;
         if (w < GRID_MIN) w = GRID_MIN;
         if (w > ROW_BITS) w = ROW_BITS;
         return w;
      endfunction

      function int active_height();
         int h;
         h = height_reg;
         if (h < GRID_MIN) h = GRID_MIN;
         if (h > HEIGHT_CAP) h = HEIGHT_CAP;
         return h;
      endfunction

      // B3/S23 on inner cells; edge columns copy the middle row
      function bit [ROW_BITS-1:0] evolve_row(bit [ROW_BITS-1:0] above, bit [ROW_BITS-1:0] mid,
                                             bit [ROW_BITS-1:0] below, int w);
         bit [ROW_BITS-1:0] res;
         int                n;
         res = mid & (64'd1 | (64'd1 << (w - 1)));
         for (int x = 1; x + 1 < w; x++) begin
            n = int'(above[x-1]) + int'(above[x]) + int'(above[x+1])
              + int'(mid[x-1]) + int'(mid[x+1])
              + int'(below[x-1]) + int'(below[x]) + int'(below[x+1]);
            if (n == 3 || (n == 2 && mid[x])) res[x] = 1'b1;
         end
         return res;
      endfunction

      function void push_expected(bit [ROW_BITS-1:0] cells, bit [ROW_NUM_BITS-1:0] row,
                                  bit last);
         rsp_entry_type entry;
         entry.next_cells = cells;
         entry.row_number = row;
         entry.frame_last = last;
         expected_rows.push_back(entry);
      endfunction

      function void add_input_row(logic [ROW_BITS-1:0] cells);
         int                w;
         int                h;
         bit [ROW_BITS-1:0] mask;
         bit [ROW_BITS-1:0] row;
         w = active_width();
         h = active_height();
         mask = (w >= ROW_BITS) ? '1 : ((64'd1 << w) - 64'd1);
         row = cells & mask;
         rows_fed++;
         if (next_row == 0) begin
            push_expected(row, '0, 1'b0);
         end else if (next_row >= 2) begin
            push_expected(evolve_row(upper_row, middle_row, row, w), next_row - 1'b1, 1'b0);
         end
         if (next_row >= h - 1) begin
            push_expected(row, next_row, 1'b1);
            restart_frame();
            frames_done++;
         end else begin
            next_row   = next_row + 1'b1;
            upper_row  = middle_row;
            middle_row = row;
         end
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         if (errors <= 40) $display("mismatch: %s got %h expected %h", what, got, want);
      endtask

      task check_output_row(logic [ROW_BITS-1:0] cells, logic [ROW_NUM_BITS-1:0] row,
                            logic last);
         rsp_entry_type want;
         results_seen++;
         if (expected_rows.size() == 0) begin
            report($sformatf("result for row %0d with none pending", row), cells, '0);
            return;
         end
         want = expected_rows.pop_front();
         if (cells !== want.next_cells)
            report($sformatf("next_cells of row %0d", want.row_number), cells, want.next_cells);
         if (row !== want.row_number)
            report("row_number", 64'(row), 64'(want.row_number));
         if (last !== want.frame_last)
            report($sformatf("frame_last of row %0d", want.row_number), 64'(last),
                   64'(want.frame_last));
      endtask
   endclass

endpackage

// ===== tb/life_automaton_row_step_test.sv =====
`timescale 1ns / 1ps
// Top-level test of life_automaton_row_step: directed patterns, then random rows over many
// grid settings with sender and receiver idling. Depends on lars_pkg and life_row_scoreboard_pkg.
module life_automaton_row_step_test;
   import lars_pkg::*;
   import life_row_scoreboard_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ROWS    = 100;
   localparam int PHASE_COUNT   = 16;
   localparam int SETTLE_CYCLES = 4;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [ROW_BITS-1:0]     req_row_cells = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [ROW_BITS-1:0]     rsp_next_cells;
   logic [ROW_NUM_BITS-1:0] rsp_row_number;
   logic                    rsp_frame_last;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [2:0]              csr_paddr = '0;
   logic [31:0]             csr_pwdata = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int cycle_count    = 0;
   int settings_used  = 1;

   int widths[PHASE_COUNT]  = '{64, 3, 127, 0, 64, 5, 2, 33, 64, 1, 63, 8, 100, 64, 4, 65};
   int heights[PHASE_COUNT] = '{3, 4, 7, 0, 17, 8191, 5, 1, 2, 10, 64, 4096, 6, 9, 3, 33};

   life_row_scoreboard board;

   life_automaton_row_step i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_row_cells  (req_row_cells),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_next_cells (rsp_next_cells),
      .rsp_row_number (rsp_row_number),
      .rsp_frame_last (rsp_frame_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_output_row(rsp_next_cells, rsp_row_number, rsp_frame_last);
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   function automatic logic [ROW_BITS-1:0] random_row();
      logic [ROW_BITS-1:0] a;
      logic [ROW_BITS-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: begin
            return $urandom_range(0, 1) ? '1 : '0;
         end
         1, 2: begin
            return a & b;
         end
         3: begin
            return a | b;
         end
         default: begin
            return a;
         end
      endcase
   endfunction

   task automatic send_row(input logic [ROW_BITS-1:0] cells);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_row_cells <= cells;
      do @(posedge clock); while (!req_ready);
      board.add_input_row(cells);
   endtask

   // drop valid and hold until every expected item has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_register(index, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [WIDTH_BITS-1:0] width,
                            input logic [HEIGHT_BITS-1:0] height);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(REG_GRID_WIDTH, ($urandom & ~32'h7F) | 32'(width));
      write_csr(REG_GRID_HEIGHT, ($urandom & ~32'h1FFF) | 32'(height));
      settings_used++;
   endtask

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_row('1);
      send_row('0);
      send_row(64'hAAAA_AAAA_AAAA_AAAA);
      send_row(64'h5555_5555_5555_5555);

      configure(7'd64, 13'd3);
      send_row(64'h8000_0000_0000_0001);
      send_row(64'hFFFF_FFFF_0000_0007);
      send_row(64'h8000_0000_0000_0002);

      configure(7'd5, 13'd5);
      send_row(64'hFFFF_FFFF_FFFF_FFE0);
      send_row(64'h0000_0000_0000_0004);
      send_row(64'h8000_0000_0000_0011);
      send_row(64'h0000_0000_0000_000E);
      send_row(64'h0000_0000_0000_001F);

      configure(7'd0, 13'd0);
      send_row('1);
      send_row('1);
      send_row('1);
      send_row(64'h2);
      send_row(64'h7);
      send_row(64'h2);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         configure(widths[p][WIDTH_BITS-1:0], heights[p][HEIGHT_BITS-1:0]);
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 73;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 73;
            end
            default: begin
               send_idle_pct  = 9;
               recv_stall_pct = 9;
            end
         endcase
         for (int k = 0; k < PHASE_ROWS; k++) begin
            if (p % 4 == 2 && k == PHASE_ROWS / 2) hold_until_drained();
            send_row(random_row());
         end
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d rows over %0d grid settings: %0d results checked, %0d frames closed",
               board.rows_fed, settings_used, board.results_seen, board.frames_done);
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
